[rtl/frame_tile_change_detector_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef FRAME_TILE_CHANGE_DETECTOR_MACROS_SVH
`define FRAME_TILE_CHANGE_DETECTOR_MACROS_SVH

// Check a property on each rising edge, skipped while reset is high.
`define FTCD_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on each rising edge, reset included.
`define FTCD_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ftcd_pkg.sv]
// Types, constants and helper functions of the frame tile change detector.
package ftcd_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int TILE_DEF       = 32;
  localparam int MAX_RESULTS    = 32;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [10:0] WIDTH_RST  = 11'd1024;
  localparam logic [10:0] HEIGHT_RST = 11'd1024;
  localparam logic [1:0]  MODE_8     = 2'd0;
  localparam logic [1:0]  MODE_16    = 2'd1;
  localparam logic [1:0]  MODE_32    = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_SCAN  = 2'd1,
    KIND_COPY  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_MODE   = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    B_IDLE, B_WPIX, B_TILE, B_CRD, B_CEV, B_KRD, B_KWR, B_EMIT, B_FIN, B_MRD, B_MWR
  } back_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [1:0]  mode;
    logic [10:0] x;
    logic [10:0] y;
    logic [31:0] pixel;
    logic [10:0] l;
    logic [10:0] t;
    logic [10:0] r;
    logic [10:0] b;
    logic [10:0] w;
    logic [10:0] h;
  } cmd_t;

  typedef struct packed {
    logic [10:0] l;
    logic [10:0] t;
    logic [10:0] r;
    logic [10:0] b;
    logic        changed;
    logic        last;
  } res_t;

  function automatic logic [31:0] depth_mask(logic [1:0] mode);
    logic [31:0] m;
    case (mode)
      MODE_8:  m = 32'h0000_00ff;
      MODE_16: m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic [10:0] min11(logic [10:0] a, logic [10:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/ftcd_ifs.sv]
// Valid/ready channel interfaces for input items and result items.
interface ftcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  x;
  logic [9:0]  y;
  logic [31:0] pixel;
  logic [9:0]  left;
  logic [9:0]  top;
  logic [10:0] right;
  logic [10:0] bottom;
  modport source (output valid, kind, x, y, pixel, left, top, right, bottom, input ready);
  modport sink (input valid, kind, x, y, pixel, left, top, right, bottom, output ready);
endinterface

interface ftcd_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  tile_left;
  logic [9:0]  tile_top;
  logic [10:0] tile_right;
  logic [10:0] tile_bottom;
  logic        changed;
  logic        last;
  modport source (output valid, tile_left, tile_top, tile_right, tile_bottom, changed, last,
                  input ready);
  modport sink (input valid, tile_left, tile_top, tile_right, tile_bottom, changed, last,
                output ready);
endinterface

[rtl/ftcd_front.sv]
// Front end: accept items, clamp coordinates and turn them into commands.
module ftcd_front
  import ftcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int TILE       = TILE_DEF
) (
  ftcd_in_if.sink     item_in,
  input  logic [10:0] frame_width,
  input  logic [10:0] frame_height,
  input  logic [1:0]  pixel_mode,
  input  logic        full,
  output logic        push,
  output cmd_t        cmd
);

  logic [10:0] fw, fh, x, y, l, t, r, b, la, rml, bmt, fwx, fhy;
  logic [11:0] t_tile;
  logic        keep;

  always_comb begin
    if (frame_width == 11'd0) fw = 11'd1;
    else if ({21'd0, frame_width} > MAX_WIDTH) fw = 11'(MAX_WIDTH);
    else fw = frame_width;
    if (frame_height == 11'd0) fh = 11'd1;
    else if ({21'd0, frame_height} > MAX_HEIGHT) fh = 11'(MAX_HEIGHT);
    else fh = frame_height;
    x = {1'b0, item_in.x};
    y = {1'b0, item_in.y};
    l = min11({1'b0, item_in.left}, fw);
    t = min11({1'b0, item_in.top}, fh);
    r = min11(item_in.right, fw);
    b = min11(item_in.bottom, fh);
    case (pixel_mode)
      MODE_8:  la = {l[10:2], 2'b00};
      MODE_16: la = {l[10:1], 1'b0};
      default: la = l;
    endcase
    t_tile = {1'b0, t} + 12'(TILE);
    rml = r - l;
    bmt = b - t;
    fwx = fw - x;
    fhy = fh - y;

    cmd.kind  = kind_t'(item_in.kind);
    cmd.mode  = pixel_mode;
    cmd.x     = x;
    cmd.y     = y;
    cmd.pixel = item_in.pixel & depth_mask(pixel_mode);
    cmd.l     = l;
    cmd.t     = t;
    cmd.r     = r;
    cmd.b     = b;
    cmd.w     = min11(rml, fwx);
    cmd.h     = min11(bmt, fhy);
    case (kind_t'(item_in.kind))
      KIND_WRITE: keep = (x < fw) && (y < fh);
      KIND_SCAN: begin
        keep  = 1'b1;
        cmd.l = la;
        cmd.b = (t_tile < {1'b0, b}) ? t_tile[10:0] : b;
      end
      KIND_COPY: keep = (l < r) && (t < b) && (x < fw) && (y < fh);
      default:   keep = (l < r) && (t < b);
    endcase
  end

  assign item_in.ready = !full;
  assign push = item_in.valid && !full && keep;

endmodule

[rtl/ftcd_queue.sv]
// Short command queue between the front end and the back end.
module ftcd_queue
  import ftcd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic valid,
  input  logic pop,
  output cmd_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  cmd_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [CNW-1:0] count;
  logic           do_push, do_pop;

  assign full    = (count == CNW'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNW'(do_push) - CNW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/ftcd_back.sv]
// Back end: frame memories and the sequencer that carries out commands.
module ftcd_back
  import ftcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int TILE       = TILE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  cmd_t q_cmd,
  output logic pop,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  localparam int NPIX = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int NW   = $clog2(MAX_RESULTS + 1);

  function automatic logic [AW-1:0] pix_addr(logic [10:0] pr, logic [10:0] pc);
    return AW'({21'd0, pr} * MAX_WIDTH + {21'd0, pc});
  endfunction

  logic [31:0] new_mem [NPIX];
  logic [31:0] ref_mem [NPIX];

  back_state_t state, state_next;
  cmd_t        c;
  logic [10:0] tx, row, col, cl_lo, cl_hi, rw_hi, ri, ci, ro, co;
  logic [NW-1:0] n;
  logic        rf, cf, cp_scan, pend_valid, out_valid;
  res_t        pend, out_q;
  logic [31:0] nrd, rrd;

  logic          nwe, rwe;
  logic [AW-1:0] nra, rra, nwa, rwa;
  logic [31:0]   nwd, rwd;
  logic          col_last, row_last, diff, out_free, tile_go, mv_col_last, mv_done;
  logic [11:0]   tx_tile;
  logic [10:0]   tr_calc;

  always_comb begin
    col_last    = ({1'b0, col} + 12'd1) == {1'b0, cl_hi};
    row_last    = ({1'b0, row} + 12'd1) == {1'b0, rw_hi};
    diff        = ((nrd ^ rrd) & depth_mask(c.mode)) != 32'd0;
    out_free    = !out_valid || res_ready;
    tile_go     = (c.t < c.b) && (tx < c.r) && (n < NW'(MAX_RESULTS));
    tx_tile     = {1'b0, tx} + 12'(TILE);
    tr_calc     = (tx_tile < {1'b0, c.r}) ? tx_tile[10:0] : c.r;
    mv_col_last = ({1'b0, ci} + 12'd1) == {1'b0, c.w};
    mv_done     = mv_col_last && (({1'b0, ri} + 12'd1) == {1'b0, c.h});

    state_next = state;
    pop = 1'b0;
    nwe = 1'b0;
    rwe = 1'b0;
    nra = pix_addr(row, col);
    rra = pix_addr(row, col);
    nwa = pix_addr(c.y, c.x);
    rwa = pix_addr(row, col);
    nwd = c.pixel;
    rwd = nrd;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop = 1'b1;
          case (q_cmd.kind)
            KIND_WRITE: state_next = B_WPIX;
            KIND_SCAN:  state_next = B_TILE;
            KIND_COPY:  state_next = B_MRD;
            default:    state_next = B_KRD;
          endcase
        end
      end
      B_WPIX: begin
        nwe = 1'b1;
        state_next = B_IDLE;
      end
      B_TILE: state_next = tile_go ? B_CRD : B_FIN;
      B_CRD:  state_next = B_CEV;
      B_CEV: begin
        if (diff) state_next = B_KRD;
        else if (!col_last || !row_last) state_next = B_CRD;
        else state_next = B_TILE;
      end
      B_KRD: state_next = B_KWR;
      B_KWR: begin
        rwe = 1'b1;
        if (col_last && row_last) state_next = cp_scan ? B_EMIT : B_IDLE;
        else state_next = B_KRD;
      end
      B_EMIT: begin
        if (!pend_valid || out_free) state_next = B_TILE;
      end
      B_FIN: begin
        if (out_free) state_next = B_IDLE;
      end
      B_MRD: begin
        rra = pix_addr(c.y + ro, c.x + co);
        state_next = B_MWR;
      end
      B_MWR: begin
        rwe = 1'b1;
        rwa = pix_addr(c.t + ro, c.l + co);
        rwd = rrd;
        state_next = mv_done ? B_IDLE : B_MRD;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (nwe) new_mem[nwa] <= nwd;
    nrd <= new_mem[nra];
  end

  always_ff @(posedge clk) begin
    if (rwe) ref_mem[rwa] <= rwd;
    rrd <= ref_mem[rra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && res_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_valid) begin
            c       <= q_cmd;
            tx      <= q_cmd.l;
            n       <= '0;
            cp_scan <= (q_cmd.kind == KIND_SCAN);
            row     <= q_cmd.t;
            col     <= q_cmd.l;
            cl_lo   <= q_cmd.l;
            cl_hi   <= q_cmd.r;
            rw_hi   <= q_cmd.b;
            rf      <= q_cmd.t < q_cmd.y;
            cf      <= q_cmd.l < q_cmd.x;
            ri      <= '0;
            ci      <= '0;
            ro      <= (q_cmd.t < q_cmd.y) ? 11'd0 : q_cmd.h - 11'd1;
            co      <= (q_cmd.l < q_cmd.x) ? 11'd0 : q_cmd.w - 11'd1;
            pend_valid <= 1'b0;
          end
        end
        B_TILE: begin
          if (tile_go) begin
            cl_lo <= tx;
            cl_hi <= tr_calc;
            rw_hi <= c.b;
            row   <= c.t;
            col   <= tx;
          end
        end
        B_CEV: begin
          if (diff) begin
            row <= c.t;
            col <= cl_lo;
          end else if (!col_last) begin
            col <= col + 11'd1;
          end else if (!row_last) begin
            row <= row + 11'd1;
            col <= cl_lo;
          end else begin
            tx <= tx_tile[10:0];
          end
        end
        B_KWR: begin
          if (!col_last) begin
            col <= col + 11'd1;
          end else if (!row_last) begin
            row <= row + 11'd1;
            col <= cl_lo;
          end
        end
        B_EMIT: begin
          if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_q     <= pend;
              out_valid <= 1'b1;
            end
            pend       <= '{l: cl_lo, t: c.t, r: cl_hi, b: rw_hi, changed: 1'b1, last: 1'b0};
            pend_valid <= 1'b1;
            n          <= n + 1'b1;
            tx         <= tx_tile[10:0];
          end
        end
        B_FIN: begin
          if (out_free) begin
            if (pend_valid) begin
              out_q <= '{l: pend.l, t: pend.t, r: pend.r, b: pend.b, changed: 1'b1,
                         last: 1'b1};
            end else begin
              out_q <= '{l: 11'd0, t: 11'd0, r: 11'd0, b: 11'd0, changed: 1'b0, last: 1'b1};
            end
            out_valid  <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        B_MWR: begin
          if (mv_col_last) begin
            ci <= '0;
            co <= cf ? 11'd0 : c.w - 11'd1;
            ri <= ri + 11'd1;
            ro <= rf ? ro + 11'd1 : ro - 11'd1;
          end else begin
            ci <= ci + 11'd1;
            co <= cf ? co + 11'd1 : co - 11'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid = out_valid;
  assign res       = out_q;

endmodule

[rtl/frame_tile_change_detector.sv]
// Top level of the frame tile change detector.
// Input items arrive on item_in (valid/ready); results leave on res_out.
// Configuration (frame_width, frame_height, pixel_mode) is written over the
// APB port at byte addresses 0, 4 and 8; the user must write it only while
// the block is idle, which the block does not enforce. The front end accepts
// one item a cycle into a two-entry command queue while it is not full, and
// drops writes and rectangles outside the frame. The back end writes a pixel
// in its write state. A scan compares each tile pixel by pixel and copies a
// changed tile into the reference memory; a rectangle copy or clear also
// goes pixel by pixel. Each pixel needs a read state before its compare or
// write state, as each frame memory has one read port with registered data.
// A scan yields one result per changed tile, or a single empty result; the
// final result carries last. Results sit in an output register; a stalled
// receiver halts the back end, the queue fills and then ready drops.
// Reset empties the queue, clears pending results and restores the default
// configuration; the frame memories are not cleared.
module frame_tile_change_detector
  import ftcd_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int TILE       = TILE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ftcd_in_if.sink     item_in,
  ftcd_out_if.source  res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [10:0] frame_width, frame_height;
  logic [1:0]  pixel_mode;
  logic        push, full, q_valid, pop, res_valid;
  cmd_t        push_cmd, q_cmd;
  res_t        res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RST;
      frame_height <= HEIGHT_RST;
      pixel_mode   <= MODE_32;
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WIDTH:  frame_width  <= pwdata[10:0];
        REG_HEIGHT: frame_height <= pwdata[10:0];
        REG_MODE:   pixel_mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WIDTH:  prdata = {21'd0, frame_width};
      REG_HEIGHT: prdata = {21'd0, frame_height};
      REG_MODE:   prdata = {30'd0, pixel_mode};
      default:    prdata = 32'd0;
    endcase
  end

  ftcd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .TILE(TILE)) u_front (
    .item_in      (item_in),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pixel_mode   (pixel_mode),
    .full         (full),
    .push         (push),
    .cmd          (push_cmd)
  );

  ftcd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .valid    (q_valid),
    .pop      (pop),
    .head     (q_cmd)
  );

  ftcd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .TILE(TILE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_out.ready),
    .res       (res)
  );

  assign res_out.valid       = res_valid;
  assign res_out.tile_left   = res.l[9:0];
  assign res_out.tile_top    = res.t[9:0];
  assign res_out.tile_right  = res.r;
  assign res_out.tile_bottom = res.b;
  assign res_out.changed     = res.changed;
  assign res_out.last        = res.last;

endmodule

[rtl/ftcd_checker.sv]
// Port-level checker for the frame tile change detector, with its bind.
`include "frame_tile_change_detector_macros.svh"

module ftcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  tile_left,
  input logic [9:0]  tile_top,
  input logic [10:0] tile_right,
  input logic [10:0] tile_bottom,
  input logic        changed,
  input logic        last
);

  `FTCD_CHECK_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result shown after reset")
  `FTCD_CHECK(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(tile_right), "stalled item changed")
  `FTCD_CHECK(a_empty_last, clk, rst, out_valid && !changed |-> last && tile_left == 10'd0 && tile_right == 11'd0, "empty result malformed")
  `FTCD_CHECK(a_tile_shape, clk, rst, out_valid && changed |-> tile_right > {1'b0, tile_left} && tile_bottom > {1'b0, tile_top}, "changed tile empty")

endmodule

bind frame_tile_change_detector ftcd_checker u_ftcd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (res_out.valid),
  .out_ready   (res_out.ready),
  .tile_left   (res_out.tile_left),
  .tile_top    (res_out.tile_top),
  .tile_right  (res_out.tile_right),
  .tile_bottom (res_out.tile_bottom),
  .changed     (res_out.changed),
  .last        (res_out.last)
);
